/* rtl/ale_pkg.sv */
package ale_pkg;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned LINK_W = 7;
  localparam int unsigned CNT_W  = 7;

  // all-ones link code marks the end of the list
  localparam logic [LINK_W-1:0] LINK_NULL = '1;

  typedef enum logic [1:0] {
    REQ_HEAD = 2'd0,
    REQ_TAIL = 2'd1,
    REQ_DEL  = 2'd2,
    REQ_READ = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAKE,
    S_TAIL,
    S_DEL,
    S_READ,
    S_RESP
  } state_e;

endpackage

/* rtl/ale_req_if.sv */
interface ale_req_if import ale_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              req_type;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink (input valid, input req_type, input value, output ready);
endinterface

/* rtl/ale_res_if.sv */
interface ale_res_if import ale_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] item_value;
  logic [CNT_W-1:0]        removed_count;
  logic [1:0]              status;
  logic                    last;

  modport source (output valid, output item_value, output removed_count, output status,
                  output last, input ready);
  modport sink (input valid, input item_value, input removed_count, input status,
                input last, output ready);
endinterface

/* rtl/array_linked_list_engine.sv */
// Singly linked list of signed 32-bit values kept in node memories, with a stack of free
// node indices. A request inserts at the head, inserts at the tail after walking the list,
// deletes every node equal to a value (freed nodes go back on the free stack), or reads the
// list out in order, one transfer per element. Inserts and deletes answer with one transfer;
// an insert into a full store is refused with status 1, a delete or read out of an empty
// list answers status 2. One request is worked on at a time and the request channel is
// ready only while the engine is idle. Timing is set by the single read port of the link
// memory, which serves one node per cycle; a read out holds on any stall of the result
// channel. Link and free stack contents come out of reset through per-entry valid bits,
// so the engine is usable right after reset with no clearing pass.
module array_linked_list_engine import ale_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ale_req_if.sink   req_i,
  ale_res_if.source res_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] DepthC = CNT_W'(DEPTH);

  // sequencer state
  state_e              state_q, state_d;
  req_e                req_q, req_d;
  logic [VAL_W-1:0]    val_q, val_d;
  logic [CNT_W-1:0]    free_top_q, free_top_d;
  logic [LINK_W-1:0]   head_q, head_d;
  logic [IW-1:0]       node_q, node_d;     // node taken by an insert
  logic [IW-1:0]       cur_q, cur_d;       // node under the walk
  logic [LINK_W-1:0]   prev_q, prev_d;     // last kept node during delete
  logic [CNT_W-1:0]    cnt_q, cnt_d;       // walk step count
  logic [CNT_W-1:0]    removed_q, removed_d;
  status_e             status_q, status_d;

  // output register
  logic                out_vld_q, out_vld_d;
  logic                out_load;
  logic [VAL_W-1:0]    out_item_q, out_item_d;
  logic [CNT_W-1:0]    out_rem_q, out_rem_d;
  status_e             out_st_q, out_st_d;
  logic                out_last_q, out_last_d;
  logic                can_load;

  // memory ports
  logic                val_we, val_re;
  logic [IW-1:0]       val_waddr, val_raddr;
  logic [VAL_W-1:0]    val_wdata, val_rdata;
  logic                link_we, link_re;
  logic [IW-1:0]       link_waddr, link_raddr;
  logic [LINK_W-1:0]   link_wdata, link_rdata;
  logic                fs_we, fs_re;
  logic [IW-1:0]       fs_waddr, fs_raddr;
  logic [IW-1:0]       fs_wdata, fs_rdata;

  // per-entry valid bits stand in for the reset contents
  logic [DEPTH-1:0]    link_vld_q;
  logic [DEPTH-1:0]    fs_vld_q;
  logic                link_rv_q;
  logic                fs_rv_q;
  logic [IW-1:0]       fs_ra_q;

  // effective read data
  logic [LINK_W-1:0]   link_rd;
  logic [IW-1:0]       fs_rd;
  logic                head_node;
  logic                nxt_node;
  logic [CNT_W-1:0]    cnt_inc;
  logic [CNT_W-1:0]    ft_dec;

  ale_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH), .AW(IW)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .re_i    (val_re),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  ale_ram #(.WIDTH(LINK_W), .DEPTH(DEPTH), .AW(IW)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (link_re),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  ale_ram #(.WIDTH(IW), .DEPTH(DEPTH), .AW(IW)) u_fs_ram (
    .clk_i   (clk_i),
    .we_i    (fs_we),
    .waddr_i (fs_waddr),
    .wdata_i (fs_wdata),
    .re_i    (fs_re),
    .raddr_i (fs_raddr),
    .rdata_o (fs_rdata)
  );

  // never-written link reads as null, never-written stack slot holds its own index
  assign link_rd   = link_rv_q ? link_rdata : LINK_NULL;
  assign fs_rd     = fs_rv_q ? fs_rdata : fs_ra_q;
  assign head_node = (head_q < DepthC);
  assign nxt_node  = (link_rd < DepthC);
  assign cnt_inc   = cnt_q + CNT_W'(1);
  assign ft_dec    = free_top_q - CNT_W'(1);
  assign can_load  = !out_vld_q || res_o.ready;

  // requests are taken only between walks
  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    val_d      = val_q;
    free_top_d = free_top_q;
    head_d     = head_q;
    node_d     = node_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    cnt_d      = cnt_q;
    removed_d  = removed_q;
    status_d   = status_q;

    out_load   = 1'b0;
    out_item_d = '0;
    out_rem_d  = '0;
    out_st_d   = ST_OK;
    out_last_d = 1'b1;

    val_we     = 1'b0;
    val_waddr  = '0;
    val_wdata  = val_q;
    val_re     = 1'b0;
    val_raddr  = '0;
    link_we    = 1'b0;
    link_waddr = '0;
    link_wdata = LINK_NULL;
    link_re    = 1'b0;
    link_raddr = '0;
    fs_we      = 1'b0;
    fs_waddr   = '0;
    fs_wdata   = cur_q;
    fs_re      = 1'b0;
    fs_raddr   = '0;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          req_d     = req_e'(req_i.req_type);
          val_d     = req_i.value;
          removed_d = '0;
          cnt_d     = '0;
          status_d  = ST_OK;
          case (req_e'(req_i.req_type))
            REQ_HEAD, REQ_TAIL: begin
              if (free_top_q >= DepthC) begin
                status_d = ST_FULL;
                state_d  = S_RESP;
              end else begin
                // pop the free stack
                fs_re    = 1'b1;
                fs_raddr = free_top_q[IW-1:0];
                state_d  = S_TAKE;
              end
            end
            REQ_DEL, REQ_READ: begin
              if (!head_node) begin
                status_d = ST_EMPTY;
                state_d  = S_RESP;
              end else begin
                link_re    = 1'b1;
                link_raddr = head_q[IW-1:0];
                val_re     = 1'b1;
                val_raddr  = head_q[IW-1:0];
                cur_d      = head_q[IW-1:0];
                prev_d     = LINK_NULL;
                state_d    = (req_e'(req_i.req_type) == REQ_DEL) ? S_DEL : S_READ;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_TAKE: begin
        // fill the new node, then link it in at the head or walk to the tail
        node_d     = fs_rd;
        free_top_d = free_top_q + CNT_W'(1);
        val_we     = 1'b1;
        val_waddr  = fs_rd;
        val_wdata  = val_q;
        link_we    = 1'b1;
        link_waddr = fs_rd;
        if (req_q == REQ_HEAD || !head_node) begin
          link_wdata = head_q;
          head_d     = LINK_W'(fs_rd);
          state_d    = S_RESP;
        end else begin
          link_wdata = LINK_NULL;
          link_re    = 1'b1;
          link_raddr = head_q[IW-1:0];
          cur_d      = head_q[IW-1:0];
          cnt_d      = '0;
          state_d    = S_TAIL;
        end
      end

      S_TAIL: begin
        if (nxt_node && cnt_q < DepthC) begin
          cur_d      = link_rd[IW-1:0];
          cnt_d      = cnt_inc;
          link_re    = 1'b1;
          link_raddr = link_rd[IW-1:0];
        end else begin
          // cur is the tail: hang the new node behind it
          link_we    = 1'b1;
          link_waddr = cur_q;
          link_wdata = LINK_W'(node_q);
          state_d    = S_RESP;
        end
      end

      S_DEL: begin
        cnt_d = cnt_inc;
        if (val_rdata == val_q) begin
          // unlink cur and push it back on the free stack
          if (prev_q < DepthC) begin
            link_we    = 1'b1;
            link_waddr = prev_q[IW-1:0];
            link_wdata = link_rd;
          end else begin
            head_d = link_rd;
          end
          if (free_top_q != '0) begin
            free_top_d = ft_dec;
            fs_we      = 1'b1;
            fs_waddr   = ft_dec[IW-1:0];
            fs_wdata   = cur_q;
          end
          removed_d = removed_q + CNT_W'(1);
        end else begin
          prev_d = LINK_W'(cur_q);
        end
        if (nxt_node && cnt_inc < DepthC) begin
          cur_d      = link_rd[IW-1:0];
          link_re    = 1'b1;
          link_raddr = link_rd[IW-1:0];
          val_re     = 1'b1;
          val_raddr  = link_rd[IW-1:0];
        end else begin
          status_d = ST_OK;
          state_d  = S_RESP;
        end
      end

      S_READ: begin
        // one transfer per node; read data holds while the output stalls
        if (can_load) begin
          out_load   = 1'b1;
          out_item_d = val_rdata;
          out_rem_d  = '0;
          out_st_d   = ST_OK;
          out_last_d = !nxt_node || (cnt_inc >= DepthC);
          cnt_d      = cnt_inc;
          if (!nxt_node || (cnt_inc >= DepthC)) begin
            state_d = S_IDLE;
          end else begin
            cur_d      = link_rd[IW-1:0];
            link_re    = 1'b1;
            link_raddr = link_rd[IW-1:0];
            val_re     = 1'b1;
            val_raddr  = link_rd[IW-1:0];
          end
        end
      end

      S_RESP: begin
        if (can_load) begin
          out_load   = 1'b1;
          out_item_d = '0;
          out_rem_d  = removed_q;
          out_st_d   = status_q;
          out_last_d = 1'b1;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      free_top_q <= '0;
      head_q     <= LINK_NULL;
      out_vld_q  <= 1'b0;
      link_vld_q <= '0;
      fs_vld_q   <= '0;
      link_rv_q  <= 1'b0;
      fs_rv_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      free_top_q <= free_top_d;
      head_q     <= head_d;
      out_vld_q  <= out_vld_d;
      if (link_we) begin
        link_vld_q[link_waddr] <= 1'b1;
      end
      if (fs_we) begin
        fs_vld_q[fs_waddr] <= 1'b1;
      end
      if (link_re) begin
        link_rv_q <= link_vld_q[link_raddr];
      end
      if (fs_re) begin
        fs_rv_q <= fs_vld_q[fs_raddr];
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    val_q     <= val_d;
    node_q    <= node_d;
    cur_q     <= cur_d;
    prev_q    <= prev_d;
    cnt_q     <= cnt_d;
    removed_q <= removed_d;
    status_q  <= status_d;
    if (fs_re) begin
      fs_ra_q <= fs_raddr;
    end
    if (out_load) begin
      out_item_q <= out_item_d;
      out_rem_q  <= out_rem_d;
      out_st_q   <= out_st_d;
      out_last_q <= out_last_d;
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.item_value    = out_item_q;
  assign res_o.removed_count = out_rem_q;
  assign res_o.status        = out_st_q;
  assign res_o.last          = out_last_q;

endmodule

/* rtl/ale_ram.sv */
module ale_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    // read data holds while no read is issued
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* dv/array_linked_list_engine_checker.sv */
module array_linked_list_engine_checker import ale_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  ale_req_if   req_i,
  ale_res_if   res_i,
  output int   requests_o,
  output int   results_o,
  output int   refused_o,
  output int   peak_removed_o,
  output int   errors_o,
  output int   pending_o
);

  typedef struct packed {
    logic signed [VAL_W-1:0] item;
    logic [CNT_W-1:0]        removed;
    status_e                 status;
    logic                    last;
  } answer_t;

  // shadow copy of the node store
  logic [VAL_W-1:0]  node_val [DEPTH];
  logic [LINK_W-1:0] node_nxt [DEPTH];
  logic [5:0]        free_idx [DEPTH];
  int unsigned       used_cnt;
  logic [LINK_W-1:0] head_ptr;

  answer_t answers_due [$];

  function automatic void queue_answer(logic [VAL_W-1:0] item, int removed, status_e st,
                                       logic fin);
    answer_t a;
    a.item    = item;
    a.removed = removed[CNT_W-1:0];
    a.status  = st;
    a.last    = fin;
    answers_due.push_back(a);
  endfunction

  function automatic void clear_store();
    for (int i = 0; i < int'(DEPTH); i++) begin
      node_val[i] = '0;
      node_nxt[i] = LINK_NULL;
      free_idx[i] = i[5:0];
    end
    used_cnt = 0;
    head_ptr = LINK_NULL;
  endfunction

  // work out the answers one request produces and update the shadow store
  function automatic void walk_list(req_e kind, logic [VAL_W-1:0] v);
    int p;
    int t;
    int steps;
    int cur;
    int prev;
    int nxt;
    int removed;
    int n;
    logic fin;
    case (kind)
      REQ_HEAD, REQ_TAIL: begin
        if (used_cnt >= DEPTH) begin
          queue_answer('0, 0, ST_FULL, 1'b1);
          refused_o++;
        end else begin
          p = free_idx[used_cnt % DEPTH];
          used_cnt++;
          node_val[p] = v;
          node_nxt[p] = LINK_NULL;
          if (kind == REQ_HEAD || head_ptr >= DEPTH) begin
            node_nxt[p] = head_ptr;
            head_ptr = p[LINK_W-1:0];
          end else begin
            t = head_ptr;
            steps = 0;
            while (node_nxt[t] < DEPTH && steps < int'(DEPTH)) begin
              t = node_nxt[t];
              steps++;
            end
            node_nxt[t] = p[LINK_W-1:0];
          end
          queue_answer('0, 0, ST_OK, 1'b1);
        end
      end
      REQ_DEL: begin
        if (head_ptr >= DEPTH) begin
          queue_answer('0, 0, ST_EMPTY, 1'b1);
        end else begin
          cur = head_ptr;
          prev = LINK_NULL;
          removed = 0;
          steps = 0;
          while (cur < int'(DEPTH) && steps < int'(DEPTH)) begin
            nxt = node_nxt[cur];
            steps++;
            if (node_val[cur] == v) begin
              if (prev < int'(DEPTH)) node_nxt[prev] = nxt[LINK_W-1:0];
              else head_ptr = nxt[LINK_W-1:0];
              // freed node goes back on the stack, not its successor
              node_val[cur] = '1;
              node_nxt[cur] = LINK_NULL;
              if (used_cnt > 0) begin
                used_cnt--;
                free_idx[used_cnt % DEPTH] = cur[5:0];
              end
              removed++;
            end else begin
              prev = cur;
            end
            cur = nxt;
          end
          if (removed > peak_removed_o) peak_removed_o = removed;
          queue_answer('0, removed, ST_OK, 1'b1);
        end
      end
      default: begin
        cur = head_ptr;
        n = 0;
        if (cur >= int'(DEPTH)) begin
          queue_answer('0, 0, ST_EMPTY, 1'b1);
        end else begin
          while (cur < int'(DEPTH) && n < int'(DEPTH)) begin
            nxt = node_nxt[cur];
            fin = (nxt >= int'(DEPTH)) || (n + 1 >= int'(DEPTH));
            queue_answer(node_val[cur], 0, ST_OK, fin);
            n++;
            cur = nxt;
          end
        end
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      clear_store();
      answers_due.delete();
      requests_o = 0;
      results_o = 0;
      refused_o = 0;
      peak_removed_o = 0;
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        requests_o++;
        walk_list(req_e'(req_i.req_type), req_i.value);
      end
      if (res_i.valid && res_i.ready) begin
        results_o++;
        if (answers_due.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("%0t: result with nothing outstanding: item %0d removed %0d status %0d last %0b",
                     $time, res_i.item_value, res_i.removed_count, res_i.status, res_i.last);
        end else begin
          want = answers_due.pop_front();
          if (res_i.item_value !== want.item || res_i.removed_count !== want.removed ||
              res_i.status !== want.status || res_i.last !== want.last) begin
            errors_o++;
            if (errors_o <= 10) begin
              $display("%0t: mismatch, expected item %0d removed %0d status %0d last %0b",
                       $time, want.item, want.removed, want.status, want.last);
              $display("%0t:           got      item %0d removed %0d status %0d last %0b",
                       $time, res_i.item_value, res_i.removed_count, res_i.status,
                       res_i.last);
            end
          end
        end
      end
      pending_o = answers_due.size();
    end
  end

endmodule

/* dv/array_linked_list_engine_tb.sv */
module array_linked_list_engine_tb;
  import ale_pkg::*;

  localparam int unsigned DEPTH = 64;
  // worst case is far below this: every request a full read out under a slow receiver
  localparam int CYCLE_LIMIT = 400000;
  // a tail insert walks the whole list, so let the engine settle a little longer than that
  localparam int SETTLE = 2 * DEPTH + 16;

  logic clk_i;
  logic rst_ni;

  ale_req_if req_if ();
  ale_res_if res_if ();

  int requests;
  int results;
  int refused;
  int peak_removed;
  int errors;
  int pending;
  int cycles;

  // calm turns off idling on both sides; hold_req asks the receiver for one long stall
  bit calm;
  bit hold_req;

  // values inserted outside the pool, kept so a drain can delete them again
  logic [VAL_W-1:0] extra_vals [$];

  array_linked_list_engine #(.DEPTH(DEPTH)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  array_linked_list_engine_checker #(.DEPTH(DEPTH)) chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_if),
    .res_i          (res_if),
    .requests_o     (requests),
    .results_o      (results),
    .refused_o      (refused),
    .peak_removed_o (peak_removed),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run-away guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("array_linked_list_engine regression: fail");
      $finish;
    end
  end

  // small value pool so deletes hit duplicates, extremes included
  function automatic logic [VAL_W-1:0] pool_value(int k);
    case (k)
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'h8000_0000;
      5:       return 32'd42;
      6:       return 32'h5A5A_5A5A;
      default: return 32'hA5A5_A5A5;
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] v;
    if ($urandom_range(99) < 75) begin
      v = pool_value($urandom_range(7));
    end else begin
      v = $urandom();
      if (extra_vals.size() < 64) extra_vals.push_back(v);
    end
    return v;
  endfunction

  // del_pct sets how hard the mix pulls the list down
  function automatic req_e pick_kind(int del_pct);
    int r;
    r = $urandom_range(99);
    if (r < del_pct) return REQ_DEL;
    if (r < del_pct + 20) return REQ_READ;
    return ($urandom_range(1) != 0) ? REQ_TAIL : REQ_HEAD;
  endfunction

  // one request transfer, entered and left at a falling edge
  task automatic send(req_e kind, logic [VAL_W-1:0] v);
    while (!calm && $urandom_range(99) < 35) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.value    <= v;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  task automatic send_mixed(int count, int del_pct);
    for (int i = 0; i < count; i++) send(pick_kind(del_pct), pick_value());
  endtask

  task automatic send_inserts(int count);
    for (int i = 0; i < count; i++)
      send(($urandom_range(1) != 0) ? REQ_TAIL : REQ_HEAD, pick_value());
  endtask

  // delete every pool value and every extra value kept since the last drain
  task automatic drain_list();
    for (int k = 0; k < 8; k++) send(REQ_DEL, pool_value(k));
    foreach (extra_vals[i]) send(REQ_DEL, extra_vals[i]);
    extra_vals.delete();
  endtask

  // stop offering requests and wait for every answer
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // receiver side: random stalls, plus one long hold counted here
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (calm) begin
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= ($urandom_range(99) >= 35);
      end
    end
  end

  // stimulus and verdict
  initial begin
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_HEAD;
    req_if.value    = '0;
    res_if.ready    = 1'b0;
    cycles          = 0;
    calm            = 1'b0;
    hold_req        = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty list answers first
    send(REQ_READ, 32'h0);
    send(REQ_DEL, 32'd5);
    // build 7, min, max, 0, -1, 7 with both insert kinds
    send(REQ_HEAD, 32'h7FFF_FFFF);
    send(REQ_HEAD, 32'h8000_0000);
    send(REQ_TAIL, 32'h0000_0000);
    send(REQ_TAIL, 32'hFFFF_FFFF);
    send(REQ_HEAD, 32'd7);
    send(REQ_TAIL, 32'd7);
    send(REQ_READ, 32'h0);
    // no match, then a match at both ends at once
    send(REQ_DEL, 32'd123);
    send(REQ_DEL, 32'd7);
    // head node alone, then tail node alone
    send(REQ_DEL, 32'h8000_0000);
    send(REQ_DEL, 32'hFFFF_FFFF);
    // read out ignores the value field
    send(REQ_READ, 32'hDEAD_BEEF);
    send(REQ_DEL, 32'h7FFF_FFFF);
    send(REQ_DEL, 32'h0000_0000);
    send(REQ_READ, 32'hFFFF_FFFF);
    // tail insert into an empty list, then a duplicate at the head
    send(REQ_TAIL, 32'd9);
    send(REQ_HEAD, 32'd9);
    send(REQ_DEL, 32'd9);
    send(REQ_READ, 32'h0);

    // random growth with reads and deletes mixed in
    send_mixed(80, 15);

    // sender pauses until every answer is back
    wait_idle();
    drain_list();

    // full store of one value while the receiver sits on its first answers
    hold_req = 1'b1;
    for (int i = 0; i < int'(DEPTH); i++)
      send(($urandom_range(1) != 0) ? REQ_TAIL : REQ_HEAD, 32'd42);
    send(REQ_HEAD, $urandom());
    send(REQ_TAIL, $urandom());
    send(REQ_READ, $urandom());
    send(REQ_DEL, 32'd42);
    wait_idle();

    // back-to-back stretch with no idling on either side
    calm = 1'b1;
    send_mixed(40, 20);
    calm = 1'b0;

    // overfill with mostly pool values, read it out, then pull it down
    send_inserts(DEPTH + 2);
    send(REQ_READ, $urandom());
    send_mixed(30, 50);
    drain_list();
    send(REQ_READ, $urandom());

    wait_idle();
    repeat (SETTLE) @(negedge clk_i);

    $display("covered %0d requests, %0d result transfers, %0d inserts refused on a full store",
             requests, results, refused);
    $display("largest delete removed %0d nodes; %0d mismatches, %0d answers outstanding",
             peak_removed, errors, pending);
    if (errors == 0 && pending == 0) begin
      $display("array_linked_list_engine regression: pass");
    end else begin
      $display("array_linked_list_engine regression: fail");
    end
    $finish;
  end

endmodule
